// File: hw/rtl/occgrid_pkg.sv
`default_nettype none

package occgrid_pkg;

    // Grid storage size.
    localparam int MAX_ROWS = 64;
    localparam int MAX_COLS = 64;

    localparam int ROW_W  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int COL_W  = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int ADDR_W = $clog2(MAX_ROWS * MAX_COLS);

    // Field widths.
    localparam int DIM_W      = 7;
    localparam int MARGIN_W   = 6;
    localparam int POS_W      = 8;
    localparam int TYPE_W     = 2;
    localparam int RAD_W      = 6;
    localparam int ACT_W      = 3;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 7;
    localparam int WIDE_W     = 10;
    localparam int DIFF_W     = POS_W + 1;
    localparam int ERR_W      = POS_W + 3;
    localparam int E2_W       = ERR_W + 1;

    // Action codes.
    localparam logic [ACT_W-1:0] ACT_CLEAR = 3'd0;
    localparam logic [ACT_W-1:0] ACT_OPEN  = 3'd1;
    localparam logic [ACT_W-1:0] ACT_STAMP = 3'd2;
    localparam logic [ACT_W-1:0] ACT_WRITE = 3'd3;
    localparam logic [ACT_W-1:0] ACT_LINE  = 3'd4;

    // Cell codes.
    localparam logic [TYPE_W-1:0] CELL_OPEN   = 2'd0;
    localparam logic [TYPE_W-1:0] CELL_HOLE   = 2'd1;
    localparam logic [TYPE_W-1:0] CELL_OBST   = 2'd2;
    localparam logic [TYPE_W-1:0] CELL_BORDER = 2'd3;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_ROWS   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COLS   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MARGIN = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_HOLES  = 2'd3;

    localparam logic [DIM_W-1:0] DIM_RESET = 7'd64;

    typedef logic signed [POS_W-1:0]  t_pos;
    typedef logic signed [WIDE_W-1:0] t_wide;
    typedef logic [ROW_W-1:0]         t_row;
    typedef logic [COL_W-1:0]         t_col;
    typedef logic [ADDR_W-1:0]        t_addr;
    typedef logic [TYPE_W-1:0]        t_cell;

    // Configuration as seen by the datapath, sizes already saturated.
    typedef struct packed {
        logic [DIM_W-1:0]    rows;
        logic [DIM_W-1:0]    cols;
        logic [MARGIN_W-1:0] margin;
        logic                holes;
    } t_cfg;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;
        logic setup;
        logic init_setup;
        logic sweep;
        logic line_run;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic is_line;
        logic is_sweep;
        logic sweep_empty;
        logic sweep_last;
        logic line_done;
    } t_sts;

endpackage

`default_nettype wire

// File: hw/rtl/occgrid_ctrl.sv
`default_nettype none

module occgrid_ctrl (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_start,
    input  occgrid_pkg::t_sts   i_sts,
    output occgrid_pkg::t_cmd   o_cmd,
    output logic                o_busy,
    output logic                o_done
);

    typedef enum logic [2:0] {
        ST_INIT_LOAD,
        ST_INIT_RUN,
        ST_IDLE,
        ST_SETUP,
        ST_SWEEP,
        ST_LINE,
        ST_DONE
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_busy;
    logic   r_done;

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_INIT_LOAD: n_state = ST_INIT_RUN;
            ST_INIT_RUN: begin
                if (i_sts.sweep_last) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (i_start) begin
                    n_state = ST_SETUP;
                end
            end
            ST_SETUP: begin
                priority if (i_sts.is_line) begin
                    n_state = ST_LINE;
                end else if (i_sts.is_sweep) begin
                    n_state = ST_SWEEP;
                end else begin
                    n_state = ST_DONE;
                end
            end
            ST_SWEEP: begin
                if (i_sts.sweep_empty || i_sts.sweep_last) begin
                    n_state = ST_DONE;
                end
            end
            ST_LINE: begin
                if (i_sts.line_done) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    // Commands decoded from the current state.
    always_comb begin
        o_cmd            = '0;
        o_cmd.capture    = (r_state == ST_IDLE) && i_start;
        o_cmd.setup      = (r_state == ST_SETUP);
        o_cmd.init_setup = (r_state == ST_INIT_LOAD);
        o_cmd.sweep      = ((r_state == ST_SWEEP) && !i_sts.sweep_empty)
                           || (r_state == ST_INIT_RUN);
        o_cmd.line_run   = (r_state == ST_LINE);
    end

    // State and registered handshake outputs.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_INIT_LOAD;
            r_busy  <= 1'b1;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_busy  <= (n_state != ST_IDLE);
            r_done  <= (n_state == ST_DONE);
        end
    end

    assign o_busy = r_busy;
    assign o_done = r_done;

endmodule

`default_nettype wire

// File: hw/rtl/occgrid_dp.sv
`default_nettype none

module occgrid_dp (
    input  wire                                       i_clk,
    input  wire                                       i_rst_n,
    input  occgrid_pkg::t_cmd                         i_cmd,
    input  occgrid_pkg::t_cfg                         i_cfg,
    input  wire [occgrid_pkg::ACT_W-1:0]              i_action,
    input  wire signed [occgrid_pkg::POS_W-1:0]       i_x_pos,
    input  wire signed [occgrid_pkg::POS_W-1:0]       i_y_pos,
    input  wire signed [occgrid_pkg::POS_W-1:0]       i_x_end,
    input  wire signed [occgrid_pkg::POS_W-1:0]       i_y_end,
    input  wire [occgrid_pkg::TYPE_W-1:0]             i_cell_type,
    input  wire [occgrid_pkg::RAD_W-1:0]              i_radius,
    output occgrid_pkg::t_sts                         o_sts,
    output logic                                      o_blocked
);

    // Flat address of a cell.
    function automatic occgrid_pkg::t_addr addr_of(input occgrid_pkg::t_row row,
                                                   input occgrid_pkg::t_col col);
        return occgrid_pkg::ADDR_W'(row) * occgrid_pkg::ADDR_W'(occgrid_pkg::MAX_COLS)
               + occgrid_pkg::ADDR_W'(col);
    endfunction

    // Captured request.
    logic [occgrid_pkg::ACT_W-1:0]  r_act;
    occgrid_pkg::t_pos              r_x;
    occgrid_pkg::t_pos              r_y;
    occgrid_pkg::t_pos              r_xe;
    occgrid_pkg::t_pos              r_ye;
    occgrid_pkg::t_cell             r_type;
    logic [occgrid_pkg::RAD_W-1:0]  r_rad;

    // Sweep counters and bounds.
    occgrid_pkg::t_row  r_row;
    occgrid_pkg::t_col  r_col;
    occgrid_pkg::t_col  r_col_lo;
    occgrid_pkg::t_row  r_row_last;
    occgrid_pkg::t_col  r_col_last;
    logic               r_empty;
    logic               r_border;
    occgrid_pkg::t_cell r_fill;

    // Line walk.
    occgrid_pkg::t_pos                r_cx;
    occgrid_pkg::t_pos                r_cy;
    logic [occgrid_pkg::DIFF_W-1:0]   r_dx;
    logic [occgrid_pkg::DIFF_W-1:0]   r_dy;
    logic                             r_sx_neg;
    logic                             r_sy_neg;
    logic signed [occgrid_pkg::ERR_W-1:0] r_err;
    logic                             r_issue;
    logic                             r_chk_valid;
    logic                             r_chk_end;
    logic                             r_blocked;

    // Grid memory.
    occgrid_pkg::t_cell mem [occgrid_pkg::MAX_ROWS * occgrid_pkg::MAX_COLS];
    occgrid_pkg::t_cell r_rd_data;

    // Action classes.
    logic is_clear, is_point, is_stamp, is_line;

    assign is_clear = (r_act == occgrid_pkg::ACT_CLEAR);
    assign is_point = (r_act == occgrid_pkg::ACT_OPEN) || (r_act == occgrid_pkg::ACT_WRITE);
    assign is_stamp = (r_act == occgrid_pkg::ACT_STAMP);
    assign is_line  = (r_act == occgrid_pkg::ACT_LINE);

    // Bounds of a stamp or single cell write, clipped to the used grid.
    logic [occgrid_pkg::DIM_W-1:0] reach, lo_off, hi_off;
    occgrid_pkg::t_wide row_lo, row_hi, col_lo, col_hi;
    occgrid_pkg::t_wide row_lo_c, row_hi_c, col_lo_c, col_hi_c;
    occgrid_pkg::t_wide rows_w, cols_w;
    logic box_empty;

    always_comb begin
        reach  = occgrid_pkg::DIM_W'(r_rad >> 1) + occgrid_pkg::DIM_W'(i_cfg.margin);
        lo_off = is_point ? '0 : reach;
        hi_off = is_point ? occgrid_pkg::DIM_W'(1) : reach;
        rows_w = $signed({3'b000, i_cfg.rows});
        cols_w = $signed({3'b000, i_cfg.cols});
        row_lo = occgrid_pkg::WIDE_W'(r_x) - $signed({3'b000, lo_off});
        row_hi = occgrid_pkg::WIDE_W'(r_x) + $signed({3'b000, hi_off});
        col_lo = occgrid_pkg::WIDE_W'(r_y) - $signed({3'b000, lo_off});
        col_hi = occgrid_pkg::WIDE_W'(r_y) + $signed({3'b000, hi_off});
        row_lo_c = (row_lo < 0) ? '0 : row_lo;
        col_lo_c = (col_lo < 0) ? '0 : col_lo;
        row_hi_c = (row_hi > rows_w) ? rows_w : row_hi;
        col_hi_c = (col_hi > cols_w) ? cols_w : col_hi;
        box_empty = (row_lo_c >= row_hi_c) || (col_lo_c >= col_hi_c);
    end

    // Value written by the sweep; a clear puts border within the margin.
    logic [occgrid_pkg::WIDE_W-1:0] row_u, col_u, mar_u, rows_u, cols_u;
    logic               inner;
    occgrid_pkg::t_cell wr_data;
    logic               row_end, col_end;

    always_comb begin
        row_u  = occgrid_pkg::WIDE_W'(r_row);
        col_u  = occgrid_pkg::WIDE_W'(r_col);
        mar_u  = occgrid_pkg::WIDE_W'(i_cfg.margin);
        rows_u = occgrid_pkg::WIDE_W'(i_cfg.rows);
        cols_u = occgrid_pkg::WIDE_W'(i_cfg.cols);
        inner  = (row_u >= mar_u) && (row_u + mar_u < rows_u)
                 && (col_u >= mar_u) && (col_u + mar_u < cols_u);
        if (r_border) begin
            wr_data = inner ? occgrid_pkg::CELL_OPEN : occgrid_pkg::CELL_BORDER;
        end else begin
            wr_data = r_fill;
        end
        row_end = (r_row == r_row_last);
        col_end = (r_col == r_col_last);
    end

    // Line walk: issue one cell a cycle, check it when its data returns.
    logic               on_line, at_end, line_open;
    logic               chk_fin, chk_blk, iss_off;
    occgrid_pkg::t_addr rd_addr;
    logic signed [occgrid_pkg::E2_W-1:0] e2;
    logic               step_x, step_y;
    logic signed [occgrid_pkg::ERR_W-1:0] err_n;

    always_comb begin
        on_line = !r_cx[occgrid_pkg::POS_W-1] && !r_cy[occgrid_pkg::POS_W-1]
                  && (r_cx[occgrid_pkg::POS_W-2:0] < i_cfg.rows)
                  && (r_cy[occgrid_pkg::POS_W-2:0] < i_cfg.cols);
        at_end  = (r_cx == r_xe) && (r_cy == r_ye);
        rd_addr = on_line
                  ? addr_of(occgrid_pkg::ROW_W'(r_cx[occgrid_pkg::POS_W-2:0]),
                            occgrid_pkg::COL_W'(r_cy[occgrid_pkg::POS_W-2:0]))
                  : '0;
        line_open = (r_rd_data == occgrid_pkg::CELL_OPEN)
                    || (i_cfg.holes && (r_rd_data == occgrid_pkg::CELL_HOLE));
        chk_blk = r_chk_valid && !line_open;
        chk_fin = r_chk_valid && (!line_open || r_chk_end);
        iss_off = r_issue && !on_line;
        e2      = {r_err, 1'b0};
        step_x  = e2 > -$signed({3'b000, r_dy});
        step_y  = e2 < $signed({3'b000, r_dx});
        err_n   = r_err - (step_x ? $signed({2'b00, r_dy}) : '0)
                        + (step_y ? $signed({2'b00, r_dx}) : '0);
    end

    // Line set-up terms.
    logic signed [occgrid_pkg::DIFF_W-1:0] diff_x, diff_y;
    logic [occgrid_pkg::DIFF_W-1:0]        abs_x, abs_y;

    always_comb begin
        diff_x = occgrid_pkg::DIFF_W'(r_xe) - occgrid_pkg::DIFF_W'(r_x);
        diff_y = occgrid_pkg::DIFF_W'(r_ye) - occgrid_pkg::DIFF_W'(r_y);
        abs_x  = (diff_x < 0) ? -diff_x : diff_x;
        abs_y  = (diff_y < 0) ? -diff_y : diff_y;
    end

    // Request capture, sweep bounds and walk registers.
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_act  <= i_action;
            r_x    <= i_x_pos;
            r_y    <= i_y_pos;
            r_xe   <= i_x_end;
            r_ye   <= i_y_end;
            r_type <= i_cell_type;
            r_rad  <= i_radius;
        end

        if (i_cmd.init_setup) begin
            r_row      <= '0;
            r_col      <= '0;
            r_col_lo   <= '0;
            r_row_last <= occgrid_pkg::ROW_W'(occgrid_pkg::MAX_ROWS - 1);
            r_col_last <= occgrid_pkg::COL_W'(occgrid_pkg::MAX_COLS - 1);
            r_empty    <= 1'b0;
            r_border   <= 1'b0;
            r_fill     <= occgrid_pkg::CELL_OPEN;
        end else if (i_cmd.setup && is_clear) begin
            r_row      <= '0;
            r_col      <= '0;
            r_col_lo   <= '0;
            r_row_last <= occgrid_pkg::ROW_W'(i_cfg.rows - occgrid_pkg::DIM_W'(1));
            r_col_last <= occgrid_pkg::COL_W'(i_cfg.cols - occgrid_pkg::DIM_W'(1));
            r_empty    <= (i_cfg.rows == '0) || (i_cfg.cols == '0);
            r_border   <= 1'b1;
            r_fill     <= occgrid_pkg::CELL_BORDER;
        end else if (i_cmd.setup && (is_point || is_stamp)) begin
            r_row      <= row_lo_c[occgrid_pkg::ROW_W-1:0];
            r_col      <= col_lo_c[occgrid_pkg::COL_W-1:0];
            r_col_lo   <= col_lo_c[occgrid_pkg::COL_W-1:0];
            r_row_last <= occgrid_pkg::ROW_W'(row_hi_c - occgrid_pkg::WIDE_W'(1));
            r_col_last <= occgrid_pkg::COL_W'(col_hi_c - occgrid_pkg::WIDE_W'(1));
            r_empty    <= box_empty;
            r_border   <= 1'b0;
            r_fill     <= (r_act == occgrid_pkg::ACT_OPEN) ? occgrid_pkg::CELL_OPEN : r_type;
        end else if (i_cmd.sweep) begin
            if (col_end) begin
                r_col <= r_col_lo;
                r_row <= r_row + 1'b1;
            end else begin
                r_col <= r_col + 1'b1;
            end
        end

        if (i_cmd.setup && is_line) begin
            r_cx     <= r_x;
            r_cy     <= r_y;
            r_dx     <= abs_x;
            r_dy     <= abs_y;
            r_sx_neg <= !(r_x < r_xe);
            r_sy_neg <= !(r_y < r_ye);
            r_err    <= $signed({2'b00, abs_x}) - $signed({2'b00, abs_y});
        end else if (i_cmd.line_run && r_issue && on_line && !at_end) begin
            if (step_x) begin
                r_cx <= r_sx_neg ? r_cx - 1'b1 : r_cx + 1'b1;
            end
            if (step_y) begin
                r_cy <= r_sy_neg ? r_cy - 1'b1 : r_cy + 1'b1;
            end
            r_err <= err_n;
        end
        if (i_cmd.line_run) begin
            r_chk_end <= at_end;
        end
    end

    // Walk control flags and the result.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_issue     <= 1'b0;
            r_chk_valid <= 1'b0;
            r_blocked   <= 1'b0;
        end else begin
            if (i_cmd.setup && is_line) begin
                r_issue     <= 1'b1;
                r_chk_valid <= 1'b0;
            end else if (i_cmd.line_run) begin
                r_chk_valid <= r_issue && on_line;
                if (r_issue && on_line && at_end) begin
                    r_issue <= 1'b0;
                end
            end
            if (i_cmd.capture) begin
                r_blocked <= 1'b0;
            end else if (i_cmd.line_run && (chk_fin || iss_off)) begin
                r_blocked <= chk_blk || iss_off;
            end
        end
    end

    // Grid memory: one write and one registered read per cycle.
    always_ff @(posedge i_clk) begin
        if (i_cmd.sweep) begin
            mem[addr_of(r_row, r_col)] <= wr_data;
        end
        r_rd_data <= mem[rd_addr];
    end

    always_comb begin
        o_sts             = '0;
        o_sts.is_line     = is_line;
        o_sts.is_sweep    = is_clear || is_point || is_stamp;
        o_sts.sweep_empty = r_empty;
        o_sts.sweep_last  = row_end && col_end;
        o_sts.line_done   = chk_fin || iss_off;
    end

    assign o_blocked = r_blocked;

endmodule

`default_nettype wire

// File: hw/rtl/occupancy_grid_line_of_sight_core.sv
// Channel   Ports                                                          Accepted when
// request   i_action i_x_pos i_y_pos i_x_end i_y_end i_cell_type i_radius   i_start && !o_busy
// result    o_blocked                                                      o_done, one cycle
// config    i_cfg_idx i_cfg_data                                           i_cfg_we
//
// One request at a time, one result each. A clear sweeps rows*cols cells,
// a stamp its clipped area, open and write at most one cell, unused codes
// none; a line query reads the cells of its walk from the grid. The sweep
// writes and the walk reads one cell a cycle. After reset a clearing pass
// over all MAX_ROWS*MAX_COLS cells keeps o_busy high; configuration writes
// are taken throughout.
// The receiver cannot stall: o_done is high for exactly one cycle.
`default_nettype none

module occupancy_grid_line_of_sight_core (
    input  wire                                     i_clk,
    input  wire                                     i_rst_n,
    input  wire                                     i_start,
    output logic                                    o_busy,
    input  wire [occgrid_pkg::ACT_W-1:0]            i_action,
    input  wire signed [occgrid_pkg::POS_W-1:0]     i_x_pos,
    input  wire signed [occgrid_pkg::POS_W-1:0]     i_y_pos,
    input  wire signed [occgrid_pkg::POS_W-1:0]     i_x_end,
    input  wire signed [occgrid_pkg::POS_W-1:0]     i_y_end,
    input  wire [occgrid_pkg::TYPE_W-1:0]           i_cell_type,
    input  wire [occgrid_pkg::RAD_W-1:0]            i_radius,
    output logic                                    o_done,
    output logic                                    o_blocked,
    input  wire                                     i_cfg_we,
    input  wire [occgrid_pkg::CFG_IDX_W-1:0]        i_cfg_idx,
    input  wire [occgrid_pkg::CFG_DATA_W-1:0]       i_cfg_data
);

    logic [occgrid_pkg::DIM_W-1:0]    r_grid_rows;
    logic [occgrid_pkg::DIM_W-1:0]    r_grid_cols;
    logic [occgrid_pkg::MARGIN_W-1:0] r_margin;
    logic                             r_holes;

    occgrid_pkg::t_cfg cfg;
    occgrid_pkg::t_cmd cmd;
    occgrid_pkg::t_sts sts;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_rows <= occgrid_pkg::DIM_RESET;
            r_grid_cols <= occgrid_pkg::DIM_RESET;
            r_margin    <= '0;
            r_holes     <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                occgrid_pkg::CFG_ROWS:   r_grid_rows <= i_cfg_data;
                occgrid_pkg::CFG_COLS:   r_grid_cols <= i_cfg_data;
                occgrid_pkg::CFG_MARGIN: r_margin <= i_cfg_data[occgrid_pkg::MARGIN_W-1:0];
                occgrid_pkg::CFG_HOLES:  r_holes <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // Sizes saturate at the storage size.
    always_comb begin
        cfg.rows   = (int'(r_grid_rows) > occgrid_pkg::MAX_ROWS)
                     ? occgrid_pkg::DIM_W'(occgrid_pkg::MAX_ROWS) : r_grid_rows;
        cfg.cols   = (int'(r_grid_cols) > occgrid_pkg::MAX_COLS)
                     ? occgrid_pkg::DIM_W'(occgrid_pkg::MAX_COLS) : r_grid_cols;
        cfg.margin = r_margin;
        cfg.holes  = r_holes;
    end

    occgrid_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_start),
        .i_sts   (sts),
        .o_cmd   (cmd),
        .o_busy  (o_busy),
        .o_done  (o_done)
    );

    occgrid_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_cfg       (cfg),
        .i_action    (i_action),
        .i_x_pos     (i_x_pos),
        .i_y_pos     (i_y_pos),
        .i_x_end     (i_x_end),
        .i_y_end     (i_y_end),
        .i_cell_type (i_cell_type),
        .i_radius    (i_radius),
        .o_sts       (sts),
        .o_blocked   (o_blocked)
    );

    // A result strobe lasts a single cycle.
    a_done_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done)
        else $error("result strobe held for more than one cycle");

    // An accepted request makes the block busy.
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |=> o_busy)
        else $error("request accepted without going busy");

    // Only a line query can report a blocked result.
    a_blocked_line: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_blocked) |-> sts.is_line)
        else $error("blocked reported for an action other than a line query");

endmodule

`default_nettype wire

// File: sim/occupancy_grid_line_of_sight_core_tb.sv
`default_nettype none

module occupancy_grid_line_of_sight_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int HALF_PERIOD    = 1;
    localparam int RESET_CYCLES   = 11;
    localparam int WATCHDOG_LIMIT = 40000;
    localparam int TAIL_CYCLES    = 8;
    localparam int NUM_CELLS      = occgrid_pkg::MAX_ROWS * occgrid_pkg::MAX_COLS;
    localparam int WALK_LIMIT     = 1024;

    typedef struct {
        logic [occgrid_pkg::ACT_W-1:0] action;
        occgrid_pkg::t_pos             x_pos;
        occgrid_pkg::t_pos             y_pos;
        occgrid_pkg::t_pos             x_end;
        occgrid_pkg::t_pos             y_end;
        occgrid_pkg::t_cell            cell_type;
        logic [occgrid_pkg::RAD_W-1:0] radius;
    } t_grid_req;

    typedef struct {
        logic [occgrid_pkg::ACT_W-1:0] action;
        logic                          blocked;
    } t_verdict;

    // Ports of the block; the inputs are known from time zero.
    logic                               i_clk       = 1'b0;
    logic                               i_rst_n     = 1'b0;
    logic                               i_start     = 1'b0;
    logic [occgrid_pkg::ACT_W-1:0]      i_action    = occgrid_pkg::ACT_CLEAR;
    occgrid_pkg::t_pos                  i_x_pos     = '0;
    occgrid_pkg::t_pos                  i_y_pos     = '0;
    occgrid_pkg::t_pos                  i_x_end     = '0;
    occgrid_pkg::t_pos                  i_y_end     = '0;
    occgrid_pkg::t_cell                 i_cell_type = occgrid_pkg::CELL_OPEN;
    logic [occgrid_pkg::RAD_W-1:0]      i_radius    = '0;
    logic                               i_cfg_we    = 1'b0;
    logic [occgrid_pkg::CFG_IDX_W-1:0]  i_cfg_idx   = occgrid_pkg::CFG_ROWS;
    logic [occgrid_pkg::CFG_DATA_W-1:0] i_cfg_data  = '0;
    logic                               o_busy;
    logic                               o_done;
    logic                               o_blocked;

    // Shadow copy of the grid and its registers.
    occgrid_pkg::t_cell grid_cells [NUM_CELLS] = '{default: occgrid_pkg::CELL_OPEN};
    logic [occgrid_pkg::DIM_W-1:0]    cfg_rows   = occgrid_pkg::DIM_RESET;
    logic [occgrid_pkg::DIM_W-1:0]    cfg_cols   = occgrid_pkg::DIM_RESET;
    logic [occgrid_pkg::MARGIN_W-1:0] cfg_margin = '0;
    logic                             cfg_holes  = 1'b0;

    t_grid_req pending_reqs [$];
    t_verdict  verdict_q [$];
    t_grid_req next_req;
    t_grid_req seen_req;
    t_verdict  due;
    logic      req_taken     = 1'b0;
    int        send_idle_pct = 0;
    int        n_issued      = 0;
    int        n_taken       = 0;
    int        n_errors      = 0;
    int        n_blocked     = 0;
    int        n_cfg_writes  = 0;
    int        n_settings    = 1;
    int        n_by_action [2**occgrid_pkg::ACT_W] = '{default: 0};
    int        stall_cycles  = 0;

    occupancy_grid_line_of_sight_core dut (.*);

    always #(HALF_PERIOD) i_clk = ~i_clk;

    function automatic int rows_in_use();
        return (cfg_rows > occgrid_pkg::MAX_ROWS) ? occgrid_pkg::MAX_ROWS : int'(cfg_rows);
    endfunction

    function automatic int cols_in_use();
        return (cfg_cols > occgrid_pkg::MAX_COLS) ? occgrid_pkg::MAX_COLS : int'(cfg_cols);
    endfunction

    function automatic bit cell_on_grid(int r, int c);
        return r >= 0 && r < rows_in_use() && c >= 0 && c < cols_in_use();
    endfunction

    function automatic void set_cell(int r, int c, occgrid_pkg::t_cell v);
        if (cell_on_grid(r, c)) begin
            grid_cells[r * occgrid_pkg::MAX_COLS + c] = v;
        end
    endfunction

    function automatic bit cell_passable(int r, int c);
        occgrid_pkg::t_cell v;
        v = grid_cells[r * occgrid_pkg::MAX_COLS + c];
        return v == occgrid_pkg::CELL_OPEN || (cfg_holes && v == occgrid_pkg::CELL_HOLE);
    endfunction

    // Bresenham walk from start to end; stops at the first cell that is off
    // the grid or closed.
    function automatic bit sight_blocked(int r, int c, int r_end, int c_end);
        int dr, dc, sr, sc, err, e2;
        dr  = (r_end > r) ? r_end - r : r - r_end;
        dc  = (c_end > c) ? c_end - c : c - c_end;
        sr  = (r < r_end) ? 1 : -1;
        sc  = (c < c_end) ? 1 : -1;
        err = dr - dc;
        repeat (WALK_LIMIT) begin
            if (!cell_on_grid(r, c) || !cell_passable(r, c)) begin
                return 1'b1;
            end
            if (r == r_end && c == c_end) begin
                return 1'b0;
            end
            e2 = 2 * err;
            if (e2 > -dc) begin
                err -= dc;
                r   += sr;
            end
            if (e2 < dr) begin
                err += dr;
                c   += sc;
            end
        end
        return 1'b1;
    endfunction

    // Applies one request to the shadow grid and returns the blocked flag.
    function automatic logic predict_request(t_grid_req q);
        int reach, m;
        logic blk;
        blk = 1'b0;
        m   = int'(cfg_margin);
        case (q.action)
            occgrid_pkg::ACT_CLEAR: begin
                for (int i = 0; i < rows_in_use(); i++) begin
                    for (int j = 0; j < cols_in_use(); j++) begin
                        grid_cells[i * occgrid_pkg::MAX_COLS + j] =
                            (i >= m && i < rows_in_use() - m &&
                             j >= m && j < cols_in_use() - m)
                            ? occgrid_pkg::CELL_OPEN : occgrid_pkg::CELL_BORDER;
                    end
                end
            end
            occgrid_pkg::ACT_OPEN: set_cell(q.x_pos, q.y_pos, occgrid_pkg::CELL_OPEN);
            occgrid_pkg::ACT_STAMP: begin
                reach = int'(q.radius / 2) + m;
                for (int i = int'(q.x_pos) - reach; i < int'(q.x_pos) + reach; i++) begin
                    for (int j = int'(q.y_pos) - reach; j < int'(q.y_pos) + reach; j++) begin
                        set_cell(i, j, q.cell_type);
                    end
                end
            end
            occgrid_pkg::ACT_WRITE: set_cell(q.x_pos, q.y_pos, q.cell_type);
            occgrid_pkg::ACT_LINE:  blk = sight_blocked(q.x_pos, q.y_pos, q.x_end, q.y_end);
            default: ;
        endcase
        return blk;
    endfunction

    function automatic t_grid_req make_req(logic [occgrid_pkg::ACT_W-1:0] act, int x, int y,
                                           int xe, int ye, occgrid_pkg::t_cell ct, int rad);
        t_grid_req q;
        q.action    = act;
        q.x_pos     = occgrid_pkg::t_pos'(x);
        q.y_pos     = occgrid_pkg::t_pos'(y);
        q.x_end     = occgrid_pkg::t_pos'(xe);
        q.y_end     = occgrid_pkg::t_pos'(ye);
        q.cell_type = ct;
        q.radius    = occgrid_pkg::RAD_W'(rad);
        return q;
    endfunction

    // Every field drawn over its full width.
    function automatic t_grid_req any_request();
        return make_req(occgrid_pkg::ACT_W'($urandom_range(2**occgrid_pkg::ACT_W - 1)),
                        $urandom_range(255), $urandom_range(255), $urandom_range(255),
                        $urandom_range(255), occgrid_pkg::t_cell'($urandom_range(3)),
                        $urandom_range(2**occgrid_pkg::RAD_W - 1));
    endfunction

    // Mostly on the grid, sometimes just off it, now and then anywhere.
    function automatic occgrid_pkg::t_pos rand_coord(int span);
        int pick;
        if (span < 1) begin
            span = 1;
        end
        pick = $urandom_range(99);
        if (pick < 80) begin
            return occgrid_pkg::t_pos'($urandom_range(span - 1));
        end
        if (pick < 92) begin
            return occgrid_pkg::t_pos'($urandom_range(span + 5) - 3);
        end
        return occgrid_pkg::t_pos'($urandom_range(255));
    endfunction

    task automatic push_request(t_grid_req q);
        pending_reqs = {pending_reqs, q};
        n_issued++;
    endtask

    // A well-formed sequence: optional clear, a few obstacles and cell
    // edits, then a run of line queries, with the odd stray request.
    task automatic queue_scenario(int rows, int cols, inout int placed);
        t_grid_req q;
        int n;
        if ($urandom_range(5) == 0) begin
            q = any_request();
            q.action = occgrid_pkg::ACT_CLEAR;
            push_request(q);
            placed++;
        end
        n = $urandom_range(3);
        repeat (n) begin
            q = any_request();
            q.action = occgrid_pkg::ACT_STAMP;
            q.x_pos  = rand_coord(rows);
            q.y_pos  = rand_coord(cols);
            if ($urandom_range(9) != 0) begin
                q.radius = occgrid_pkg::RAD_W'($urandom_range(6));
            end
            push_request(q);
            placed++;
        end
        n = $urandom_range(4);
        repeat (n) begin
            q = any_request();
            q.action = ($urandom_range(2) == 0) ? occgrid_pkg::ACT_OPEN
                                                : occgrid_pkg::ACT_WRITE;
            q.x_pos  = rand_coord(rows);
            q.y_pos  = rand_coord(cols);
            push_request(q);
            placed++;
        end
        n = $urandom_range(8, 3);
        repeat (n) begin
            q = any_request();
            q.action = occgrid_pkg::ACT_LINE;
            q.x_pos  = rand_coord(rows);
            q.y_pos  = rand_coord(cols);
            q.x_end  = rand_coord(rows);
            q.y_end  = rand_coord(cols);
            push_request(q);
            placed++;
        end
        if ($urandom_range(7) == 0) begin
            q = any_request();
            push_request(q);
            if (q.action <= occgrid_pkg::ACT_LINE) begin
                placed++;
            end
        end
    endtask

    // Waits until every request has been taken and every result seen.
    task automatic settle();
        while (pending_reqs.size() != 0 || n_taken != n_issued || verdict_q.size() != 0) begin
            @(negedge i_clk);
        end
    endtask

    task automatic write_reg(logic [occgrid_pkg::CFG_IDX_W-1:0] idx, int value);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= occgrid_pkg::CFG_DATA_W'(value);
    endtask

    task automatic run_phase(int rows, int cols, int margin, int holes, int idle_pct,
                             int count);
        int placed;
        placed = 0;
        settle();
        write_reg(occgrid_pkg::CFG_ROWS, rows);
        write_reg(occgrid_pkg::CFG_COLS, cols);
        write_reg(occgrid_pkg::CFG_MARGIN, margin);
        write_reg(occgrid_pkg::CFG_HOLES, holes);
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        n_settings++;
        send_idle_pct = idle_pct;
        while (placed < count) begin
            queue_scenario((rows < occgrid_pkg::MAX_ROWS) ? rows : occgrid_pkg::MAX_ROWS,
                           (cols < occgrid_pkg::MAX_COLS) ? cols : occgrid_pkg::MAX_COLS,
                           placed);
        end
    endtask

    // Request driver: presents the next pending request once the previous
    // one has been taken, idling in the given share of cycles.
    always @(negedge i_clk) begin
        if (!i_start || req_taken) begin
            if (pending_reqs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                next_req = pending_reqs.pop_front();
                i_action    <= next_req.action;
                i_x_pos     <= next_req.x_pos;
                i_y_pos     <= next_req.y_pos;
                i_x_end     <= next_req.x_end;
                i_y_end     <= next_req.y_end;
                i_cell_type <= next_req.cell_type;
                i_radius    <= next_req.radius;
                i_start     <= 1'b1;
            end else begin
                i_start <= 1'b0;
            end
        end
    end

    // Monitor: checks results, tracks register writes and predicts each
    // request as it is taken.
    always @(posedge i_clk) begin
        req_taken = 1'b0;
        if (i_rst_n) begin
            if (o_done) begin
                if (verdict_q.size() == 0) begin
                    $error("Result with no request outstanding: blocked %0d", o_blocked);
                    n_errors++;
                end else begin
                    due = verdict_q.pop_front();
                    if (o_blocked !== due.blocked) begin
                        $error("blocked mismatch (action %0d): expected %0d, actual %0d",
                               due.action, due.blocked, o_blocked);
                        n_errors++;
                    end
                end
            end
            if (i_cfg_we) begin
                n_cfg_writes++;
                case (i_cfg_idx)
                    occgrid_pkg::CFG_ROWS:   cfg_rows   = i_cfg_data[occgrid_pkg::DIM_W-1:0];
                    occgrid_pkg::CFG_COLS:   cfg_cols   = i_cfg_data[occgrid_pkg::DIM_W-1:0];
                    occgrid_pkg::CFG_MARGIN: cfg_margin = i_cfg_data[occgrid_pkg::MARGIN_W-1:0];
                    occgrid_pkg::CFG_HOLES:  cfg_holes  = i_cfg_data[0];
                    default: ;
                endcase
            end
            if (i_start && !o_busy) begin
                req_taken = 1'b1;
                seen_req  = '{i_action, i_x_pos, i_y_pos, i_x_end, i_y_end,
                              i_cell_type, i_radius};
                due.action  = i_action;
                due.blocked = predict_request(seen_req);
                verdict_q = {verdict_q, due};
                n_taken++;
                n_by_action[i_action]++;
                if (due.blocked) begin
                    n_blocked++;
                end
            end
        end
    end

    // Watchdog on cycles without any request or result moving.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_start && !o_busy) || o_done) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= WATCHDOG_LIMIT) begin
            $error("No request or result moved for %0d cycles", WATCHDOG_LIMIT);
            $display("DONE: errors detected");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin
        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed requests on the reset setting: extreme coordinates, every
        // action, off-grid edits, holes counted as closed, a stamp clipped by
        // the edge, a stamp wholly off the grid and the unused action codes.
        send_idle_pct = 13;
        push_request(make_req(occgrid_pkg::ACT_LINE, 0, 0, 63, 63, occgrid_pkg::CELL_OPEN, 0));
        push_request(make_req(occgrid_pkg::ACT_LINE, -128, -128, 127, 127,
                              occgrid_pkg::CELL_BORDER, 63));
        push_request(make_req(occgrid_pkg::ACT_LINE, 127, 127, -128, -128,
                              occgrid_pkg::CELL_OPEN, 0));
        push_request(make_req(occgrid_pkg::ACT_WRITE, 10, 10, 0, 0, occgrid_pkg::CELL_OBST, 0));
        push_request(make_req(occgrid_pkg::ACT_LINE, 10, 0, 10, 20, occgrid_pkg::CELL_OPEN, 0));
        push_request(make_req(occgrid_pkg::ACT_OPEN, 10, 10, 0, 0, occgrid_pkg::CELL_BORDER, 0));
        push_request(make_req(occgrid_pkg::ACT_LINE, 10, 0, 10, 20, occgrid_pkg::CELL_OPEN, 0));
        push_request(make_req(occgrid_pkg::ACT_WRITE, 5, 5, 0, 0, occgrid_pkg::CELL_HOLE, 0));
        push_request(make_req(occgrid_pkg::ACT_LINE, 0, 0, 10, 10, occgrid_pkg::CELL_OPEN, 0));
        push_request(make_req(occgrid_pkg::ACT_WRITE, 63, 63, 0, 0,
                              occgrid_pkg::CELL_BORDER, 0));
        push_request(make_req(occgrid_pkg::ACT_WRITE, -1, 5, 0, 0, occgrid_pkg::CELL_OBST, 0));
        push_request(make_req(occgrid_pkg::ACT_WRITE, 64, 0, 0, 0, occgrid_pkg::CELL_OBST, 0));
        push_request(make_req(occgrid_pkg::ACT_OPEN, 127, -128, 0, 0,
                              occgrid_pkg::CELL_OPEN, 0));
        push_request(make_req(occgrid_pkg::ACT_LINE, 63, 0, 63, 63, occgrid_pkg::CELL_OPEN, 0));
        push_request(make_req(occgrid_pkg::ACT_STAMP, 32, 32, 0, 0, occgrid_pkg::CELL_OBST, 63));
        push_request(make_req(occgrid_pkg::ACT_LINE, 0, 0, 63, 0, occgrid_pkg::CELL_OPEN, 0));
        push_request(make_req(occgrid_pkg::ACT_LINE, 0, 63, 40, 60, occgrid_pkg::CELL_OPEN, 0));
        push_request(make_req(occgrid_pkg::ACT_STAMP, -128, -128, 0, 0,
                              occgrid_pkg::CELL_OBST, 0));
        push_request(make_req(occgrid_pkg::ACT_STAMP, 0, 0, 0, 0, occgrid_pkg::CELL_HOLE, 5));
        push_request(make_req(occgrid_pkg::ACT_STAMP, 127, 127, 0, 0,
                              occgrid_pkg::CELL_BORDER, 63));
        push_request(make_req(occgrid_pkg::ACT_CLEAR, 0, 0, 0, 0, occgrid_pkg::CELL_OPEN, 0));
        push_request(make_req(occgrid_pkg::ACT_LINE, 0, 5, 40, 9, occgrid_pkg::CELL_OPEN, 0));
        push_request(make_req(occgrid_pkg::ACT_LINE, 3, 3, 3, 3, occgrid_pkg::CELL_OPEN, 0));
        for (int k = occgrid_pkg::ACT_LINE + 1; k < 2**occgrid_pkg::ACT_W; k++) begin
            push_request(make_req(occgrid_pkg::ACT_W'(k), 7, 7, -7, 127,
                                  occgrid_pkg::CELL_BORDER, 63));
        end

        // Random sequences over several settings; sizes of zero, one and
        // above the maximum, and margins wider than half the grid.
        run_phase(64, 64, 0, 1, 13, 350);
        run_phase(20, 37, 2, 0, 13, 300);
        run_phase(1, 64, 0, 1, 61, 80);
        run_phase(64, 1, 0, 0, 61, 70);
        run_phase(127, 100, 1, 0, 61, 300);
        run_phase(0, 13, 0, 0, 61, 60);
        run_phase(9, 5, 32, 1, 0, 100);
        run_phase(64, 64, 32, 0, 0, 80);
        run_phase(48, 64, 3, 1, 0, 560);

        settle();
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("Ran %0d requests: clear %0d, open %0d, stamp %0d, write %0d, line %0d",
                 n_taken, n_by_action[occgrid_pkg::ACT_CLEAR],
                 n_by_action[occgrid_pkg::ACT_OPEN], n_by_action[occgrid_pkg::ACT_STAMP],
                 n_by_action[occgrid_pkg::ACT_WRITE], n_by_action[occgrid_pkg::ACT_LINE]);
        $display("%0d line queries blocked; %0d register writes over %0d grid settings",
                 n_blocked, n_cfg_writes, n_settings);
        if (n_errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

`default_nettype wire

// File: occupancy_grid_line_of_sight_core.f
hw/rtl/occgrid_pkg.sv
hw/rtl/occgrid_ctrl.sv
hw/rtl/occgrid_dp.sv
hw/rtl/occupancy_grid_line_of_sight_core.sv
sim/occupancy_grid_line_of_sight_core_tb.sv
